FILE: rtl/core/bra_pkg.sv
`timescale 1ns / 1ps

package bra_pkg;

    // Default store size in bytes
    localparam int MAP_BYTES_DEF = 32;

    // Configuration register
    localparam int              CFG_W       = 6;
    localparam logic [CFG_W-1:0] BYTES_RESET = 6'd32;

    // Bit positions inside the managed area (up to 63 bytes of 8 bits)
    localparam int POS_W = 9;

    localparam logic [7:0] BYTE_ALL_ONES = 8'hff;

    // Operation codes
    typedef enum logic [1:0] {
        OP_TEST  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FIND  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_BIT,
        ST_CLR,
        ST_SCAN,
        ST_REPLY
    } state_t;

    // Input word
    typedef struct packed {
        op_t        op;
        logic [7:0] mark_idx;
        logic       bit_value;
        logic [8:0] run_length;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic       bit_state;
        logic       found;
        logic [7:0] run_start;
    } out_word_t;

    // Sequencer to scan unit
    typedef struct packed {
        logic clear;
        logic step;
    } scan_ctl_t;

    // Scan unit status
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] start;
    } scan_res_t;

endpackage

FILE: rtl/core/bra_ram.sv
`timescale 1ns / 1ps

module bra_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/bra_run_scan.sv
`timescale 1ns / 1ps

module bra_run_scan (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  bra_pkg::scan_ctl_t       ctl,
    input  logic [7:0]               byte_data,
    input  logic [bra_pkg::POS_W-1:0] base_pos,
    input  logic [8:0]               run_len,
    output bra_pkg::scan_res_t       res
);

    import bra_pkg::*;

    logic [8:0]       streak_reg, streak_next;
    logic             hit_reg, hit_next;
    logic [POS_W-1:0] start_reg, start_next;

    // Walk the eight marks of one byte, lowest first; freeze at the first run
    always_comb begin
        streak_next = streak_reg;
        hit_next    = hit_reg;
        start_next  = start_reg;
        if (ctl.clear) begin
            streak_next = '0;
            hit_next    = 1'b0;
            start_next  = '0;
        end else if (ctl.step) begin
            for (int i = 0; i < 8; i++) begin
                if (!hit_next) begin
                    if (byte_data[i]) begin
                        streak_next = '0;
                    end else begin
                        streak_next = streak_next + 9'd1;
                    end
                    if (streak_next == run_len) begin
                        hit_next   = 1'b1;
                        start_next = POS_W'(base_pos + POS_W'(i) + 9'd1 - run_len);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            streak_reg <= '0;
            hit_reg    <= 1'b0;
            start_reg  <= '0;
        end else begin
            streak_reg <= streak_next;
            hit_reg    <= hit_next;
            start_reg  <= start_next;
        end
    end

    assign res.hit   = hit_reg;
    assign res.start = start_reg;

endmodule

FILE: rtl/core/bitmap_run_allocator.sv
`timescale 1ns / 1ps

// Bitmap run allocator: MAP_BYTES bytes of allocation marks, bit n in byte n/8.
// Input channel (s_valid/s_ready/s_data) takes one command word: test a mark,
// write a mark, find the lowest run of free marks, or clear the bytes in use.
// Result channel (m_valid/m_ready/m_data) returns exactly one word per command.
// Config channel (cfg_valid/cfg_ready/cfg_data) sets bytes_in_use; always ready,
// write it only while no command is in flight.
// Test and write use one byte in the bit state; clear-all writes N bytes and
// find reads up to N bytes, where N is min(bytes_in_use, MAP_BYTES). Find
// stops early at the first run; a zero or oversized length, a clear-all with
// N zero, or a test or write past the store goes straight to the reply state.
// The map is a single-port-write, registered-read RAM, scanned one byte per
// cycle through one shared byte scanner; that byte rate sets the find time.
// One command is handled at a time; s_ready is high only in idle, and the next
// command can be accepted on the edge that takes the result, so none overlap.
// Reset: a clearing pass writes zero to every map byte, with s_ready low;
// bytes_in_use returns to 32.
// A stalled receiver holds the result in the output register; a new command
// may be accepted meanwhile and waits at its end for the register to drain.
module bitmap_run_allocator #(
    parameter int MAP_BYTES = bra_pkg::MAP_BYTES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  bra_pkg::in_word_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output bra_pkg::out_word_t        m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bra_pkg::CFG_W-1:0] cfg_data
);

    import bra_pkg::*;

    localparam int ADDR_W   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CMP_W    = (ADDR_W > CFG_W) ? ADDR_W : CFG_W;
    localparam int MAP_BITS = MAP_BYTES * 8;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              issue_done_reg, issue_done_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              rd_last_reg, rd_last_next;
    logic [CFG_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              bitv_reg, bitv_next;
    in_word_t          item_reg;
    logic [CFG_W-1:0]  bytes_in_use_reg;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;

    logic [CFG_W-1:0]  active;
    logic              ptr_at_last;
    logic              accept;
    logic              out_free;
    logic              in_range;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic [7:0]        bit_sel;

    scan_ctl_t         scan_ctl;
    scan_res_t         scan_res;

    // Config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_in_use_reg <= BYTES_RESET;
        end else if (cfg_valid) begin
            bytes_in_use_reg <= cfg_data;
        end
    end

    // Effective byte count and end of sweep
    always_comb begin
        if (32'(bytes_in_use_reg) > MAP_BYTES) begin
            active = CFG_W'(MAP_BYTES);
        end else begin
            active = bytes_in_use_reg;
        end
    end

    assign ptr_at_last = (CMP_W'(ptr_reg) == CMP_W'(active - 6'd1));
    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign in_range    = (32'(s_data.mark_idx) < MAP_BITS);
    assign bit_sel     = 8'd1 << item_reg.mark_idx[2:0];

    // Map store
    bra_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared byte scanner
    assign scan_ctl.clear = accept;
    assign scan_ctl.step  = (state_reg == ST_SCAN) && rd_vld_reg;

    bra_run_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .byte_data (ram_rdata),
        .base_pos  ({rd_idx_reg, 3'b000}),
        .run_len   (item_reg.run_length),
        .res       (scan_res)
    );

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        issue_done_next = issue_done_reg;
        rd_vld_next     = 1'b0;
        rd_last_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        bitv_next       = bitv_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = '0;
        ram_raddr       = ptr_reg;

        case (state_reg)
            ST_INIT: begin
                ram_we = 1'b1;
                if (ptr_reg == ADDR_W'(MAP_BYTES - 1)) begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            ST_IDLE: begin
                ram_raddr = ADDR_W'(s_data.mark_idx[7:3]);
                if (accept) begin
                    ptr_next        = '0;
                    issue_done_next = 1'b0;
                    bitv_next       = 1'b0;
                    case (s_data.op)
                        OP_TEST, OP_WRITE: begin
                            state_next = in_range ? ST_BIT : ST_REPLY;
                        end
                        OP_FIND: begin
                            if (s_data.run_length == 9'd0 ||
                                s_data.run_length > {active, 3'b000}) begin
                                state_next = ST_REPLY;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = (active == '0) ? ST_REPLY : ST_CLR;
                        end
                    endcase
                end
            end

            // Byte of a test or write is on the read port
            ST_BIT: begin
                ram_waddr = ADDR_W'(item_reg.mark_idx[7:3]);
                bitv_next = ram_rdata[item_reg.mark_idx[2:0]];
                if (item_reg.op == OP_WRITE) begin
                    ram_we = 1'b1;
                    if (item_reg.bit_value) begin
                        ram_wdata = ram_rdata | bit_sel;
                    end else begin
                        ram_wdata = ram_rdata & (BYTE_ALL_ONES ^ bit_sel);
                    end
                end
                state_next = ST_REPLY;
            end

            ST_CLR: begin
                ram_we = 1'b1;
                if (ptr_at_last) begin
                    state_next = ST_REPLY;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            // Read one byte per cycle, scan the one read last cycle
            ST_SCAN: begin
                if (!issue_done_reg) begin
                    rd_vld_next  = 1'b1;
                    rd_last_next = ptr_at_last;
                    rd_idx_next  = CFG_W'(ptr_reg);
                    if (ptr_at_last) begin
                        issue_done_next = 1'b1;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
                if (scan_res.hit || (rd_vld_reg && rd_last_reg)) begin
                    rd_vld_next = 1'b0;
                    state_next  = ST_REPLY;
                end
            end

            ST_REPLY: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.bit_state = (item_reg.op == OP_TEST) && bitv_reg;
                    m_data_next.found     = 1'b0;
                    m_data_next.run_start = '0;
                    if (item_reg.op == OP_FIND && scan_res.hit &&
                        !scan_res.start[POS_W-1]) begin
                        m_data_next.found     = 1'b1;
                        m_data_next.run_start = scan_res.start[7:0];
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            ptr_reg        <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            rd_last_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            rd_last_reg    <= rd_last_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        bitv_reg   <= bitv_next;
        m_data_reg <= m_data_next;
        if (accept) begin
            item_reg <= s_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/bra_checker.sv
`timescale 1ns / 1ps

module bra_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input bra_pkg::out_word_t        m_data
);

    // A held result word stays until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // One command at a time: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accept");

    // A failed or non-find result carries a zero start
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |-> m_data.run_start == 8'd0)
        else $error("run start set without found");

    // Test and find fields never both set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bit_state |-> !m_data.found)
        else $error("bit state and found both set");

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);
